FILE: hw/rtl/mvn_pkg.sv
// shared types and constants for the matrix-vector sign normalizer
`timescale 1ns / 1ps
`default_nettype none
package mvn_pkg;

  localparam int DIM       = 8;
  localparam int ROW_W     = 3;
  localparam int IDX_W     = 6;
  localparam int MAT_DEPTH = DIM * DIM;
  localparam int VAL_W     = 32;
  localparam int Y_W       = 48;
  localparam int ACC_W     = 52;
  localparam int B_W       = 28;
  localparam int NUM_W     = B_W + 30;
  localparam int DIV_STEPS = NUM_W;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_MAT = 2'd0,
    CMD_LOAD_VEC = 2'd1,
    CMD_EVAL     = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_ROW_END,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_INIT,
    ST_SQRT_STEP,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_OUT_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             wr_mat;
    logic             wr_vec;
    logic             mac_clr;
    logic             mac_mul;
    logic             mac_acc;
    logic             row_end;
    logic             norm_step;
    logic             sq_mul;
    logic             sq_acc;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             out_load;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic norm_done;
    logic out_valid;
    logic out_taken;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mvn_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module mvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mvn_ctrl.sv
// sequencer for load, multiply-accumulate, normalize, sqrt, divide and emit
`timescale 1ns / 1ps
`default_nettype none
module mvn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [1:0]      s_tuser,
  input  wire logic [5:0]      in_index,
  input  wire mvn_pkg::dp_sts_t sts,
  output mvn_pkg::dp_cmd_t     cmd
);
  import mvn_pkg::*;

  state_t           state, state_next;
  logic [ROW_W-1:0] row, row_next;
  logic [ROW_W-1:0] col, col_next;
  logic [5:0]       cnt, cnt_next;
  logic             accept;
  cmd_t             in_cmd;

  assign accept = s_tvalid && (state == ST_IDLE);
  assign in_cmd = cmd_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_EVAL) begin
          state_next = ST_MAC_RD;
          row_next   = '0;
          col_next   = '0;
        end
      end
      ST_MAC_RD:  state_next = ST_MAC_MUL;
      ST_MAC_MUL: state_next = ST_MAC_ACC;
      ST_MAC_ACC: begin
        if (col == ROW_W'(DIM - 1)) begin
          state_next = ST_ROW_END;
        end else begin
          col_next   = col + 1'b1;
          state_next = ST_MAC_RD;
        end
      end
      ST_ROW_END: begin
        col_next = '0;
        if (row == ROW_W'(DIM - 1)) begin
          state_next = ST_NORM;
          row_next   = '0;
        end else begin
          row_next   = row + 1'b1;
          state_next = ST_MAC_RD;
        end
      end
      ST_NORM: begin
        if (sts.m_zero) begin
          state_next = ST_OUT_LOAD;
        end else if (sts.norm_done) begin
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: state_next = ST_SQ_ACC;
      ST_SQ_ACC: begin
        if (row == ROW_W'(DIM - 1)) begin
          state_next = ST_SQRT_INIT;
          row_next   = '0;
        end else begin
          row_next   = row + 1'b1;
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQRT_INIT: begin
        cnt_next   = '0;
        state_next = ST_SQRT_STEP;
      end
      ST_SQRT_STEP: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cnt_next   = '0;
        state_next = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          state_next = ST_OUT_LOAD;
        end
      end
      ST_OUT_LOAD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_taken) begin
          if (row == ROW_W'(DIM - 1)) begin
            state_next = ST_IDLE;
            row_next   = '0;
          end else begin
            row_next   = row + 1'b1;
            state_next = sts.m_zero ? ST_OUT_LOAD : ST_DIV_INIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.row   = row;
    cmd.col   = col;
    s_tready  = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.wr_mat  = accept && in_cmd == CMD_LOAD_MAT;
        // vector positions beyond the dimension are dropped
        cmd.wr_vec  = accept && in_cmd == CMD_LOAD_VEC && in_index < IDX_W'(DIM);
        cmd.mac_clr = accept && in_cmd == CMD_EVAL;
      end
      ST_MAC_MUL:   cmd.mac_mul   = 1'b1;
      ST_MAC_ACC:   cmd.mac_acc   = 1'b1;
      ST_ROW_END:   cmd.row_end   = 1'b1;
      ST_NORM:      cmd.norm_step = 1'b1;
      ST_SQ_MUL:    cmd.sq_mul    = 1'b1;
      ST_SQ_ACC:    cmd.sq_acc    = 1'b1;
      ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
      ST_SQRT_STEP: cmd.sqrt_step = 1'b1;
      ST_DIV_INIT:  cmd.div_init  = 1'b1;
      ST_DIV_STEP:  cmd.div_step  = 1'b1;
      ST_OUT_LOAD:  cmd.out_load  = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mvn_dp.sv
// datapath: stores, multiply-accumulate, scaling, square root, divider, output beat
`timescale 1ns / 1ps
`default_nettype none
module mvn_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mvn_pkg::dp_cmd_t cmd,
  output mvn_pkg::dp_sts_t      sts,
  input  wire logic [5:0]       in_index,
  input  wire logic [31:0]      in_value,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [2:0]            out_row,
  output logic [31:0]           out_result,
  output logic                  out_degen,
  output logic                  out_last
);
  import mvn_pkg::*;

  logic [15:0]             zero_threshold;
  logic [VAL_W-1:0]        mat_rdata;
  logic [VAL_W-1:0]        vec [DIM];
  logic signed [Y_W-1:0]   yv [DIM];
  logic signed [63:0]      preg;
  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0]   ysat;
  logic [Y_W-1:0]          ymag;
  logic [Y_W-1:0]          mmax;
  logic                    flip;
  logic [4:0]              rsh;
  logic [4:0]              lsh;
  logic [B_W-1:0]          bcur;
  logic [2*B_W-1:0]        sq;
  logic [63:0]             sum;
  logic [63:0]             s_rem;
  logic [63:0]             s_root;
  logic [63:0]             s_bit;
  logic [63:0]             s_try;
  logic [30:0]             rem;
  logic [31:0]             rem2;
  logic [NUM_W-1:0]        num;
  logic [30:0]             q;
  logic                    neg;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 1;

  mvn_ram #(.WIDTH(VAL_W), .DEPTH(MAT_DEPTH)) u_mat (
    .clk   (clk),
    .we    (cmd.wr_mat),
    .waddr (in_index),
    .wdata (in_value),
    .raddr ({cmd.row, cmd.col}),
    .rdata (mat_rdata)
  );

  function automatic logic [Y_W-1:0] mag_of(input logic signed [Y_W-1:0] y);
    return y[Y_W-1] ? Y_W'(-y) : Y_W'(y);
  endfunction

  assign ysat = (acc > SAT_MAX) ? Y_W'(SAT_MAX) :
                (acc < SAT_MIN) ? Y_W'(SAT_MIN) : Y_W'(acc);
  assign ymag = mag_of(ysat);
  // common scale: right shift truncates, left shift is exact
  assign bcur = B_W'((mag_of(yv[cmd.row]) >> rsh) << lsh);
  assign s_try = s_root + s_bit;
  assign rem2  = {rem, num[NUM_W-1]};
  assign q     = num[30:0];
  assign neg   = yv[cmd.row][Y_W-1] ^ flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= 16'd1;
    end else if (cfg_we) begin
      zero_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vec) begin
      vec[in_index[ROW_W-1:0]] <= in_value;
    end
    if (cmd.mac_mul) begin
      preg <= $signed(mat_rdata) * $signed(vec[cmd.col]);
    end
    if (cmd.mac_clr || cmd.row_end) begin
      acc <= '0;
    end else if (cmd.mac_acc) begin
      // arithmetic shift is the floor to q.16
      acc <= acc + ACC_W'(preg >>> 16);
    end
    if (cmd.mac_clr) begin
      mmax <= '0;
      flip <= 1'b0;
      rsh  <= '0;
      lsh  <= '0;
    end else if (cmd.row_end) begin
      yv[cmd.row] <= ysat;
      if (ymag > mmax) begin
        mmax <= ymag;
        flip <= ysat[Y_W-1];
      end
    end else if (cmd.norm_step) begin
      if (mmax[Y_W-1:B_W] != '0) begin
        mmax <= mmax >> 1;
        rsh  <= rsh + 1'b1;
      end else if (!mmax[B_W-1] && mmax != '0) begin
        mmax <= mmax << 1;
        lsh  <= lsh + 1'b1;
      end
    end
    if (cmd.sq_mul) begin
      sq <= bcur * bcur;
    end
    if (cmd.mac_clr) begin
      sum <= '0;
    end else if (cmd.sq_acc) begin
      sum <= sum + 64'(sq);
    end
    if (cmd.sqrt_init) begin
      s_rem  <= sum;
      s_root <= '0;
      s_bit  <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (s_rem >= s_try) begin
        s_rem  <= s_rem - s_try;
        s_root <= (s_root >> 1) + s_bit;
      end else begin
        s_root <= s_root >> 1;
      end
      s_bit <= s_bit >> 2;
    end
    // restoring divide, quotient bits shift in behind the numerator
    if (cmd.div_init) begin
      num <= {bcur, 30'd0};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= s_root[31:0]) begin
        rem <= 31'(rem2 - s_root[31:0]);
        num <= {num[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem2[30:0];
        num <= {num[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row   <= cmd.row;
      out_degen <= (mmax == '0);
      out_last  <= (cmd.row == ROW_W'(DIM - 1));
      if (mmax == '0 || 32'(q) <= 32'(zero_threshold)) begin
        out_result <= '0;
      end else begin
        out_result <= neg ? 32'(-32'(q)) : 32'(q);
      end
    end
  end

  assign sts.m_zero    = (mmax == '0);
  assign sts.norm_done = (mmax[Y_W-1:B_W] == '0) && mmax[B_W-1];
  assign sts.out_valid = m_tvalid;
  assign sts.out_taken = m_tvalid && m_tready;

  a_scaled_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sq_mul |-> (mmax[Y_W-1:B_W] == '0 && mmax[B_W-1]))
    else $error("peak magnitude not scaled into range");
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (32'(rem) < s_root[31:0]))
    else $error("divider remainder not below divisor");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_tvalid)
    else $error("output beat overwritten before taken");
endmodule
`default_nettype wire

FILE: hw/rtl/matvec_sign_normalizer.sv
// top level: matrix-vector product with sign-fixed l2 normalization
//
//  group  dir  payload                                   handshake
//  s_*    in   tdata {value[37:6], index[5:0]}, tuser cmd  tvalid/tready
//  m_*    out  tdata {result[34:3], row[2:0]}, tuser degen, tlast  tvalid/tready
//  cfg_*  in   cfg_wdata zero_threshold                  cfg_we
//
// evaluate runs each matrix element through the single multiplier (read, multiply,
// accumulate), then the scaling steps and 32 square-root steps, then the
// bit-serial divider per row plus the output beat; a zero peak skips root and divide.
// rst is synchronous and clears the sequencer, output valid and threshold (1).
// s_tready is low for the whole evaluate; a stalled output beat holds the run.
`timescale 1ns / 1ps
`default_nettype none
module matvec_sign_normalizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // index[5:0], value[37:6], zero fill
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // row[2:0], result[34:3], zero fill
  output logic             m_tuser,   // degenerate
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import mvn_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  out_row;
  logic [31:0] out_result;

  mvn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .in_index (s_tdata[5:0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_index   (s_tdata[5:0]),
    .in_value   (s_tdata[37:6]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_row    (out_row),
    .out_result (out_result),
    .out_degen  (m_tuser),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'd0, out_result, out_row};
endmodule
`default_nettype wire

FILE: tb/tb_matvec_sign_normalizer.sv
// testbench for the matrix-vector sign normalizer: directed and random beats
`timescale 1ns / 1ps
module tb_matvec_sign_normalizer;
  import mvn_pkg::*;

  localparam int DEPTH_VEC = DIM;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  typedef struct packed {
    logic [2:0]  row;
    logic [31:0] result;
    logic        degen;
    logic        last;
  } norm_out_t;

  norm_out_t   pending_rows[$];
  logic [31:0] mat_mirror[MAT_DEPTH];
  logic [31:0] vec_mirror[DEPTH_VEC];
  logic [15:0] threshold_mirror;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matvec_sign_normalizer i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // product, scale to [2^27,2^28), norm, per-row divide and sign fix
  task automatic predict_normalized();
    longint    y[DIM];
    logic [63:0] mg[DIM];
    logic [63:0] m, total, n, q;
    longint    acc, p;
    int        maxi, rsh, lsh;
    logic      flip, degen, neg;
    norm_out_t o;
    m = 0; maxi = 0; rsh = 0; lsh = 0; total = 0;
    for (int i = 0; i < DIM; i++) begin
      acc = 0;
      for (int j = 0; j < DIM; j++) begin
        p = longint'($signed(mat_mirror[i*DIM+j])) * longint'($signed(vec_mirror[j]));
        acc += p >>> 16;
      end
      if (acc > 64'sh7FFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF;
      if (acc < -64'sh8000_0000_0000) acc = -64'sh8000_0000_0000;
      y[i] = acc;
      mg[i] = acc < 0 ? -acc : acc;
      if (mg[i] > m) begin
        m = mg[i];
        maxi = i;
      end
    end
    degen = (m == 0);
    flip = y[maxi] < 0;
    n = 1;
    if (!degen) begin
      while ((m >> rsh) >= (64'd1 << 28)) rsh++;
      if (rsh == 0) while ((m << lsh) < (64'd1 << 27)) lsh++;
      for (int i = 0; i < DIM; i++) begin
        mg[i] = (mg[i] >> rsh) << lsh;
        total += mg[i] * mg[i];
      end
      n = isqrt(total);
      if (n == 0) n = 1;
    end
    for (int i = 0; i < DIM; i++) begin
      o.row = i[2:0];
      o.result = '0;
      o.degen = degen;
      o.last = (i == DIM - 1);
      if (!degen) begin
        q = (mg[i] << 30) / n;
        if (q <= threshold_mirror) q = 0;
        neg = (y[i] < 0) != flip;
        o.result = neg ? -q[31:0] : q[31:0];
      end
      pending_rows.push_back(o);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // one beat into the block, mirrored into the predictor on acceptance
  task automatic send_beat(input logic [1:0] cmd, input logic [5:0] idx,
                           input logic [31:0] value);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, value, idx};
    do @(posedge clk); while (!s_tready);
    case (cmd)
      CMD_LOAD_MAT: mat_mirror[idx] = value;
      CMD_LOAD_VEC: if (idx < DEPTH_VEC) vec_mirror[idx] = value;
      CMD_EVAL:     predict_normalized();
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_mirror = v;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(65536 * 4) - 65536 * 2;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_all(input int style);
    for (int i = 0; i < MAT_DEPTH; i++)
      send_beat(CMD_LOAD_MAT, i[5:0], style == 0 ? 32'h0 : style == 1 ? 32'h7FFF_FFFF :
                style == 2 ? 32'h8000_0000 : rand_value());
    for (int j = 0; j < DEPTH_VEC; j++)
      send_beat(CMD_LOAD_VEC, j[5:0], style == 0 ? 32'h0 : style == 1 ? 32'h7FFF_FFFF :
                style == 2 ? 32'h7FFF_FFFF : rand_value());
  endtask

  task automatic test_directed();
    load_all(0);
    send_beat(CMD_EVAL, 6'd0, 32'hFFFF_FFFF);   // zero norm
    for (int j = 0; j < DIM; j++)
      send_beat(CMD_LOAD_MAT, j[5:0], 32'h7FFF_FFFF);
    for (int j = 0; j < DEPTH_VEC; j++)
      send_beat(CMD_LOAD_VEC, j[5:0], 32'h7FFF_FFFF);
    send_beat(CMD_EVAL, 6'd63, 32'h0);          // saturation, positive
    for (int j = 0; j < DEPTH_VEC; j++)
      send_beat(CMD_LOAD_VEC, j[5:0], 32'h8000_0000);
    send_beat(CMD_LOAD_VEC, 6'd8, 32'h1234_5678); // out of range vector index
    send_beat(CMD_LOAD_VEC, 6'd63, 32'h0);
    send_beat(CMD_UNUSED, 6'd5, 32'hDEAD_BEEF);  // ignored command
    send_beat(CMD_EVAL, 6'd0, 32'h0);           // saturation, negative, flip
    for (int j = 0; j < DEPTH_VEC; j++)
      send_beat(CMD_LOAD_VEC, j[5:0], j == 3 ? 32'hFFFF_0000 : 32'h0000_0001);
    send_beat(CMD_EVAL, 6'd0, 32'h0);
  endtask

  task automatic test_threshold();
    logic [15:0] ths[4] = '{16'd0, 16'hFFFF, 16'd1000, 16'd1};
    foreach (ths[k]) begin
      write_threshold(ths[k]);
      for (int i = 0; i < 4; i++)
        send_beat(CMD_LOAD_MAT, 6'($urandom), rand_value());
      send_beat(CMD_EVAL, 6'd0, 32'h0);
    end
  endtask

  task automatic test_random(input int beats);
    int r;
    for (int k = 0; k < beats; k++) begin
      r = $urandom_range(99);
      if (r < 60) send_beat(CMD_LOAD_MAT, 6'($urandom), rand_value());
      else if (r < 80) send_beat(CMD_LOAD_VEC, 6'($urandom), rand_value());
      else if (r < 95) send_beat(CMD_EVAL, 6'($urandom), $urandom);
      else send_beat(CMD_UNUSED, 6'($urandom), $urandom);
    end
  endtask

  // receiver: random stall and compare with the oldest prediction
  always @(posedge clk) begin
    norm_out_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[34:3], 32'h0);
        end else begin
          w = pending_rows.pop_front();
          if (m_tdata[2:0] != w.row) report_mismatch("row", m_tdata[2:0], w.row);
          if (m_tdata[34:3] != w.result) report_mismatch("result", m_tdata[34:3], w.result);
          if (m_tuser != w.degen) report_mismatch("degenerate", m_tuser, w.degen);
          if (m_tlast != w.last) report_mismatch("last", m_tlast, w.last);
        end
      end
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    threshold_mirror = 16'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(12);
    send_idle_pct = 53; recv_stall_pct = 0;  test_random(12);
    send_idle_pct = 0;  recv_stall_pct = 53; test_random(12);
    send_idle_pct = 23; recv_stall_pct = 23; test_random(12);
    wait_drained();
    if (errors == 0)
      $display("tb_matvec_sign_normalizer: PASS");
    else
      $display("tb_matvec_sign_normalizer: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_matvec_sign_normalizer: FAIL");
    $finish;
  end
endmodule
